[rtl/wpsh_pkg.sv]
// Package for the weighted pair separation histogram core.
// Holds register indexes, function and status codes, and shared constants.
package wpsh_pkg;
	localparam int MAX_BINS_PAR_DEF = 64;
	localparam int MAX_BINS_TRANS_DEF = 64;

	localparam logic [1:0] FUNC_ACC = 2'd0;
	localparam logic [1:0] FUNC_READ = 2'd1;
	localparam logic [1:0] FUNC_READ_CLR = 2'd2;

	localparam logic [1:0] ST_ACC = 2'd0;
	localparam logic [1:0] ST_DROP = 2'd1;
	localparam logic [1:0] ST_CLAMP = 2'd2;
	localparam logic [1:0] ST_READ = 2'd3;

	localparam logic [1:0] REG_BINS_PAR = 2'd0;
	localparam logic [1:0] REG_BINS_TRANS = 2'd1;
	localparam logic [1:0] REG_SCALE_PAR = 2'd2;
	localparam logic [1:0] REG_SCALE_TRANS = 2'd3;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	typedef struct packed {
		logic [1:0] func;
		logic [31:0] rc_first;
		logic [31:0] rc_second;
		logic [31:0] weight_first;
		logic [31:0] weight_second;
		logic signed [31:0] delta_first;
		logic signed [31:0] delta_second;
		logic signed [31:0] cos_pair;
		logic [11:0] read_index;
	} wpsh_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [11:0] bin_index;
		logic [62:0] weight_sum;
		logic signed [63:0] delta_sum;
	} wpsh_out_t;

	// Request from the front pipeline to the store stage.
	typedef struct packed {
		logic [1:0] op;
		logic [1:0] status;
		logic [11:0] idx;
		logic in_range;
		logic [63:0] wprod;
		logic signed [63:0] dprod;
	} wpsh_req_t;
endpackage

[rtl/wpsh_stream_if.sv]
// Valid/ready channel interface for the histogram core.
// Depends on nothing; payload type is a parameter.
interface wpsh_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/wpsh_sqrt.sv]
// Iterative integer square root, two result bits per cycle.
// Depends on nothing; used twice by the histogram core front end.
module wpsh_sqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [60:0] radicand,
	output logic done,
	output logic [30:0] root
);
	logic [61:0] rem_q;
	logic [63:0] val_q;
	logic [30:0] res_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [63:0] bitv;
	logic [63:0] trial1, trial2;
	logic [63:0] r1, r2, v1, v2;
	logic [30:0] res1, res2;

	// Restoring digit-by-digit root; each step brings down two radicand bits.
	always_comb begin
		r1 = {rem_q, val_q[63:62]};
		trial1 = {31'd0, res_q, 2'b01};
		if (r1 >= trial1) begin
			v1 = r1 - trial1;
			res1 = {res_q[29:0], 1'b1};
		end else begin
			v1 = r1;
			res1 = {res_q[29:0], 1'b0};
		end
		r2 = {v1[61:0], val_q[61:60]};
		trial2 = {31'd0, res1, 2'b01};
		if (r2 >= trial2) begin
			v2 = r2 - trial2;
			res2 = {res1[29:0], 1'b1};
		end else begin
			v2 = r2;
			res2 = {res1[29:0], 1'b0};
		end
		bitv = v2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			val_q <= {3'd0, radicand};
			res_q <= '0;
		end else if (busy_q) begin
			rem_q <= bitv[61:0];
			val_q <= {val_q[59:0], 4'd0};
			res_q <= res2;
		end
	end

	assign root = res_q;
endmodule

[rtl/weighted_pair_separation_histogram_core.sv]
// Weighted pair separation histogram: each accumulate transaction bins one pixel pair by its
// parallel and transverse separation and adds the weight and delta products into two
// 4096-entry synchronous stores; read transactions return a bin and may clear it. One
// transaction is in flight at a time. An accumulate runs two square root units in parallel,
// then multiply, scale, index and read-modify-write stages before it presents its result;
// a dropped pair skips the read-modify-write, a read passes only the store read and write-back,
// and an unused code goes straight to the result stage. The next transaction is taken once
// the result has moved to the output register, where it waits; the core only stalls when
// it finishes while the previous result is still waiting. After reset the stores are
// cleared by a pass over all MAX_BINS_PAR*MAX_BINS_TRANS entries, during which no
// transaction is taken.
module weighted_pair_separation_histogram_core #(
	parameter int MAX_BINS_PAR = wpsh_pkg::MAX_BINS_PAR_DEF,
	parameter int MAX_BINS_TRANS = wpsh_pkg::MAX_BINS_TRANS_DEF
) (
	input logic clk,
	input logic arst_n,
	wpsh_stream_if.sink in_ch,
	wpsh_stream_if.source out_ch,
	input logic cfg_we,
	input logic [wpsh_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [wpsh_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wpsh_pkg::*;

	localparam int DEPTH = MAX_BINS_PAR * MAX_BINS_TRANS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BPW = $clog2(MAX_BINS_PAR + 1);
	localparam int BTW = $clog2(MAX_BINS_TRANS + 1);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_SQRT = 4'd2;
	localparam logic [3:0] S_MUL = 4'd3;
	localparam logic [3:0] S_SCL1 = 4'd4;
	localparam logic [3:0] S_SCL2 = 4'd5;
	localparam logic [3:0] S_IDX = 4'd6;
	localparam logic [3:0] S_RD = 4'd7;
	localparam logic [3:0] S_WB = 4'd8;
	localparam logic [3:0] S_OUT = 4'd9;

	logic [3:0] state_q;
	logic [AW:0] clr_q;
	logic [6:0] bins_par_q, bins_trans_q;
	logic [31:0] scale_par_q, scale_trans_q;
	wpsh_in_t item_q;
	wpsh_out_t res_q;
	wpsh_out_t out_q;
	logic out_valid_q;
	logic out_load;
	logic clamped_q;
	logic sqst_q;

	logic [63:0] wstore [DEPTH];
	logic [63:0] dstore [DEPTH];
	logic [63:0] wrd_s1, drd_s1;

	logic [60:0] rad_c, rad_s;
	logic sqc_done, sqs_done;
	logic [30:0] ch, sh;
	logic [32:0] diff_q, sum_q;
	logic [63:0] rp_q, rt_q;
	logic [63:0] lo_p_q, lo_t_q, hi_p_q, hi_t_q;
	logic [63:0] bp_q, bt_q;
	logic [63:0] wprod_q;
	logic signed [63:0] dprod_q;
	logic [AW-1:0] idx_q;
	logic [BPW-1:0] bp_n;
	logic [BTW-1:0] bt_n;
	logic signed [32:0] cos_c;
	logic [63:0] wsum;
	logic signed [64:0] dsum;
	logic [63:0] wnew, dnew;
	logic [63:0] flat;
	logic rd_ok;
	logic drop_c;
	logic [AW-1:0] raddr;
	logic rd_en, wr_en;
	logic [AW-1:0] waddr;
	logic [63:0] wdat, ddat;

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	// A finished result moves to the output register once the previous one has left.
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ch.ready);

	always_comb begin
		cos_c = 33'(item_q.cos_pair);
		if (item_q.cos_pair > 32'sd1073741824) cos_c = 33'sd1073741824;
		if (item_q.cos_pair < -32'sd1073741824) cos_c = -33'sd1073741824;
		rad_c = {32'(33'sd1073741824 + cos_c), 29'd0};
		rad_s = {32'(33'sd1073741824 - cos_c), 29'd0};
	end

	wpsh_sqrt u_sqrt_c (.clk(clk), .arst_n(arst_n), .start(sqst_q),
		.radicand(rad_c), .done(sqc_done), .root(ch));
	wpsh_sqrt u_sqrt_s (.clk(clk), .arst_n(arst_n), .start(sqst_q),
		.radicand(rad_s), .done(sqs_done), .root(sh));

	always_comb begin
		if (9'(bins_par_q) < 9'(MAX_BINS_PAR)) bp_n = BPW'(bins_par_q);
		else bp_n = BPW'(MAX_BINS_PAR);
		if (9'(bins_trans_q) < 9'(MAX_BINS_TRANS)) bt_n = BTW'(bins_trans_q);
		else bt_n = BTW'(MAX_BINS_TRANS);
	end

	assign flat = bp_q * 64'(bt_n) + bt_q;
	assign rd_ok = {20'd0, item_q.read_index} < 32'(DEPTH);
	assign drop_c = (bp_q >= 64'(bp_n)) || (bt_q >= 64'(bt_n)) || (flat >= 64'(DEPTH));

	always_comb begin
		wsum = wrd_s1 + wprod_q;
		if (wprod_q[63] || wsum < wrd_s1 || wsum[63]) wnew = 64'h7FFF_FFFF_FFFF_FFFF;
		else wnew = wsum;
		dsum = 65'(signed'(drd_s1)) + 65'(dprod_q);
		if (dsum > 65'sh0_7FFF_FFFF_FFFF_FFFF) dnew = 64'h7FFF_FFFF_FFFF_FFFF;
		else if (dsum < -65'sh0_8000_0000_0000_0000) dnew = 64'h8000_0000_0000_0000;
		else dnew = dsum[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
			sqst_q <= 1'b0;
			bins_par_q <= 7'd50;
			bins_trans_q <= 7'd50;
			scale_par_q <= 32'd16384;
			scale_trans_q <= 32'd16384;
		end else begin
			sqst_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_BINS_PAR: bins_par_q <= cfg_data[6:0];
					REG_BINS_TRANS: bins_trans_q <= cfg_data[6:0];
					REG_SCALE_PAR: scale_par_q <= cfg_data;
					REG_SCALE_TRANS: scale_trans_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (in_ch.valid) begin
					case (in_ch.data.func)
						FUNC_ACC: begin
							state_q <= S_SQRT;
							sqst_q <= 1'b1;
						end
						FUNC_READ, FUNC_READ_CLR: state_q <= S_RD;
						default: state_q <= S_OUT;
					endcase
				end
				S_SQRT: if (sqc_done && sqs_done) state_q <= S_MUL;
				S_MUL: state_q <= S_SCL1;
				S_SCL1: state_q <= S_SCL2;
				S_SCL2: state_q <= S_IDX;
				S_IDX: state_q <= drop_c ? S_OUT : S_RD;
				S_RD: state_q <= S_WB;
				S_WB: state_q <= S_OUT;
				S_OUT: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath and result registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			item_q <= in_ch.data;
			res_q <= '{status: ST_DROP, bin_index: '0, weight_sum: '0, delta_sum: '0};
			clamped_q <= 1'b0;
		end
		if (sqst_q) begin
			clamped_q <= item_q.cos_pair > 32'sd1073741824
				|| item_q.cos_pair < -32'sd1073741824;
			diff_q <= (item_q.rc_first > item_q.rc_second)
				? 33'(item_q.rc_first - item_q.rc_second)
				: 33'(item_q.rc_second - item_q.rc_first);
			sum_q <= 33'(item_q.rc_first) + 33'(item_q.rc_second);
		end
		if (state_q == S_MUL) begin
			rp_q <= 64'(({31'd0, diff_q} * {33'd0, ch}) >> 30);
			rt_q <= 64'(({31'd0, sum_q} * {33'd0, sh}) >> 30);
			wprod_q <= 64'(item_q.weight_first) * 64'(item_q.weight_second);
		end
		if (state_q == S_SCL1) begin
			lo_p_q <= 64'(rp_q[31:0]) * 64'(scale_par_q);
			lo_t_q <= 64'(rt_q[31:0]) * 64'(scale_trans_q);
			hi_p_q <= 64'(rp_q[33:32]) * 64'(scale_par_q);
			hi_t_q <= 64'(rt_q[33:32]) * 64'(scale_trans_q);
			dprod_q <= 64'(item_q.delta_first) * 64'(item_q.delta_second);
		end
		if (state_q == S_SCL2) begin
			bp_q <= 64'(hi_p_q[33:0]) + (lo_p_q >> 32);
			bt_q <= 64'(hi_t_q[33:0]) + (lo_t_q >> 32);
		end
		// A dropped pair keeps the drop result set when it was taken.
		if (state_q == S_IDX) begin
			if (!drop_c) begin
				res_q.status <= clamped_q ? ST_CLAMP : ST_ACC;
				res_q.bin_index <= 12'(flat);
			end
			idx_q <= AW'(flat);
		end
		if (state_q == S_RD && item_q.func != FUNC_ACC) begin
			res_q.status <= ST_READ;
			res_q.bin_index <= item_q.read_index;
			idx_q <= AW'(item_q.read_index);
		end
		if (state_q == S_WB && item_q.func != FUNC_ACC && rd_ok) begin
			res_q.weight_sum <= wrd_s1[62:0];
			res_q.delta_sum <= drd_s1;
		end
		if (out_load) out_q <= res_q;
	end

	// Store: one synchronous read port and one write port per array.
	always_comb begin
		raddr = (state_q == S_RD && item_q.func != FUNC_ACC)
			? AW'(item_q.read_index) : idx_q;
		rd_en = state_q == S_RD;
		wr_en = 1'b0;
		waddr = idx_q;
		wdat = wnew;
		ddat = dnew;
		if (state_q == S_CLEAR) begin
			wr_en = 1'b1;
			waddr = clr_q[AW-1:0];
			wdat = '0;
			ddat = '0;
		end else if (state_q == S_WB && item_q.func == FUNC_ACC) begin
			wr_en = 1'b1;
		end else if (state_q == S_WB && item_q.func == FUNC_READ_CLR && rd_ok) begin
			wr_en = 1'b1;
			wdat = '0;
			ddat = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wstore[waddr] <= wdat;
			dstore[waddr] <= ddat;
		end
		if (rd_en) begin
			wrd_s1 <= wstore[raddr];
			drd_s1 <= dstore[raddr];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_CLEAR || state_q == S_WB))
		else $error("store written outside clear or write-back");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ch.ready)
		else $error("input taken during clearing pass");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |=> out_valid_q)
		else $error("result lost while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB) |-> $past(state_q == S_RD))
		else $error("write-back without a store read");
endmodule

[tb/wpsh_hist_checker.sv]
// Scoreboard for the weighted pair separation histogram core.
// Uses wpsh_pkg and mirrors both bin stores and the four registers.
`timescale 1ns / 100ps
module wpsh_hist_checker #(
	parameter int MAX_BINS_PAR = wpsh_pkg::MAX_BINS_PAR_DEF,
	parameter int MAX_BINS_TRANS = wpsh_pkg::MAX_BINS_TRANS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input wpsh_pkg::wpsh_in_t in_data,
	input logic out_valid,
	input logic out_ready,
	input wpsh_pkg::wpsh_out_t out_data,
	input logic cfg_we,
	input logic [wpsh_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [wpsh_pkg::CFG_DATA_W-1:0] cfg_data,
	output int fail_count,
	output int pending
);
	import wpsh_pkg::*;

	localparam int DEPTH = MAX_BINS_PAR * MAX_BINS_TRANS;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam bit [63:0] WSUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	bit [63:0] weight_bins [DEPTH];
	bit [63:0] delta_bins [DEPTH];
	bit [6:0] n_par_reg, n_trans_reg;
	bit [31:0] scale_par_reg, scale_trans_reg;
	wpsh_out_t expected_results [$];

	assign pending = expected_results.size();

	function automatic bit [63:0] root_floor(bit [63:0] v);
		bit [63:0] res = 0;
		bit [63:0] b = 64'h4000_0000_0000_0000;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic bit [127:0] to_bin(bit [63:0] r, bit [31:0] s);
		bit [127:0] p = 128'(r) * 128'(s);
		return p >> 32;
	endfunction

	// Computes the result of one transaction and applies its effect on the stores.
	function automatic wpsh_out_t bin_pair(wpsh_in_t it);
		wpsh_out_t res = '0;
		longint c;
		bit clamped = 0;
		bit [63:0] ch, sh, diff, rp, rt, wp, d1, d2;
		bit [127:0] bp, bt;
		int n_par, n_trans, idx;
		bit [64:0] wsum;
		longint dp;
		logic signed [64:0] dsum;
		res.status = ST_DROP;
		case (it.func)
			FUNC_ACC: begin
				c = longint'(it.cos_pair);
				if (c > ONE_Q30) begin c = ONE_Q30; clamped = 1; end
				if (c < -ONE_Q30) begin c = -ONE_Q30; clamped = 1; end
				ch = root_floor(64'(ONE_Q30 + c) << 29);
				sh = root_floor(64'(ONE_Q30 - c) << 29);
				d1 = 64'(it.rc_first);
				d2 = 64'(it.rc_second);
				diff = d1 > d2 ? d1 - d2 : d2 - d1;
				rp = (diff * ch) >> 30;
				rt = ((d1 + d2) * sh) >> 30;
				bp = to_bin(rp, scale_par_reg);
				bt = to_bin(rt, scale_trans_reg);
				n_par = n_par_reg < MAX_BINS_PAR ? n_par_reg : MAX_BINS_PAR;
				n_trans = n_trans_reg < MAX_BINS_TRANS ? n_trans_reg : MAX_BINS_TRANS;
				if (bp < 128'(n_par) && bt < 128'(n_trans)) begin
					idx = int'(bp) * n_trans + int'(bt);
					wp = 64'(it.weight_first) * 64'(it.weight_second);
					wsum = 65'(weight_bins[idx]) + 65'(wp);
					weight_bins[idx] = (wp > WSUM_MAX || wsum > 65'(WSUM_MAX)) ?
						WSUM_MAX : wsum[63:0];
					dp = longint'(it.delta_first) * longint'(it.delta_second);
					dsum = 65'(signed'(delta_bins[idx])) + 65'(dp);
					if (dsum > 65'sh0_7FFF_FFFF_FFFF_FFFF)
						delta_bins[idx] = 64'h7FFF_FFFF_FFFF_FFFF;
					else if (dsum < -65'sh0_8000_0000_0000_0000)
						delta_bins[idx] = 64'h8000_0000_0000_0000;
					else
						delta_bins[idx] = dsum[63:0];
					res.status = clamped ? ST_CLAMP : ST_ACC;
					res.bin_index = 12'(idx);
				end
			end
			FUNC_READ, FUNC_READ_CLR: begin
				idx = int'(it.read_index);
				res.status = ST_READ;
				res.bin_index = it.read_index;
				if (idx < DEPTH) begin
					res.weight_sum = weight_bins[idx][62:0];
					res.delta_sum = delta_bins[idx];
					if (it.func == FUNC_READ_CLR) begin
						weight_bins[idx] = '0;
						delta_bins[idx] = '0;
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wpsh_out_t want;
		if (!arst_n) begin
			foreach (weight_bins[i]) begin
				weight_bins[i] = '0;
				delta_bins[i] = '0;
			end
			n_par_reg = 7'd50;
			n_trans_reg = 7'd50;
			scale_par_reg = 32'd16384;
			scale_trans_reg = 32'd16384;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BINS_PAR: n_par_reg = cfg_data[6:0];
					REG_BINS_TRANS: n_trans_reg = cfg_data[6:0];
					REG_SCALE_PAR: scale_par_reg = cfg_data;
					REG_SCALE_TRANS: scale_trans_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_results.push_back(bin_pair(in_data));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result transaction, status %0d bin %0d",
						out_data.status, out_data.bin_index);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (out_data.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, out_data.status);
						fail_count++;
					end
					if (out_data.bin_index !== want.bin_index) begin
						$error("bin_index: expected %0d, actual %0d",
							want.bin_index, out_data.bin_index);
						fail_count++;
					end
					if (out_data.weight_sum !== want.weight_sum) begin
						$error("weight_sum: expected %h, actual %h",
							want.weight_sum, out_data.weight_sum);
						fail_count++;
					end
					if (out_data.delta_sum !== want.delta_sum) begin
						$error("delta_sum: expected %h, actual %h",
							want.delta_sum, out_data.delta_sum);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

[tb/weighted_pair_separation_histogram_core_tb.sv]
// Top of the histogram core testbench: clock, reset, stimulus and verdict.
// Depends on wpsh_pkg, wpsh_stream_if, the core and wpsh_hist_checker.
`timescale 1ns / 100ps
module weighted_pair_separation_histogram_core_tb;
	import wpsh_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [31:0] COS_ONE = 32'h4000_0000;
	localparam logic [31:0] COS_MINUS_ONE = 32'hC000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int fail_count, pending;
	bit quiet_mode = 0;
	int stall_left = 0;
	int max_dist = 200;

	wpsh_stream_if #(.T(wpsh_in_t)) in_ch ();
	wpsh_stream_if #(.T(wpsh_out_t)) out_ch ();

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	weighted_pair_separation_histogram_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	wpsh_hist_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: after each transaction, hold ready low for a random number of cycles.
	always @(posedge clk or negedge arst_n) begin
		int left;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			left = stall_left;
			if (out_ch.valid && out_ch.ready)
				left = quiet_mode ? 0 : $urandom_range(0, 19);
			else if (left > 0)
				left--;
			stall_left = left;
			out_ch.ready <= (left == 0);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_grid(logic [6:0] np, logic [6:0] nt, logic [31:0] sp, logic [31:0] st);
		write_reg(REG_BINS_PAR, 32'(np));
		write_reg(REG_BINS_TRANS, 32'(nt));
		write_reg(REG_SCALE_PAR, sp);
		write_reg(REG_SCALE_TRANS, st);
		cfg_we <= 1'b0;
	endtask

	task automatic send(wpsh_in_t it);
		int gap;
		gap = quiet_mode ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.data <= it;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	function automatic wpsh_in_t pair(logic [31:0] d1, logic [31:0] d2, logic [31:0] w1,
		logic [31:0] w2, logic [31:0] dw1, logic [31:0] dw2, logic [31:0] c);
		wpsh_in_t it;
		it.func = FUNC_ACC;
		it.rc_first = d1;
		it.rc_second = d2;
		it.weight_first = w1;
		it.weight_second = w2;
		it.delta_first = dw1;
		it.delta_second = dw2;
		it.cos_pair = c;
		it.read_index = 12'($urandom);
		return it;
	endfunction

	function automatic wpsh_in_t bin_read(logic [1:0] fn, logic [11:0] idx);
		wpsh_in_t it;
		it = pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		it.func = fn;
		it.read_index = idx;
		return it;
	endfunction

	function automatic logic [31:0] near_dist();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return $urandom_range(0, max_dist * 65536);
	endfunction

	function automatic wpsh_in_t random_item();
		int pick;
		logic [31:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 78) begin
			c = ($urandom_range(0, 7) == 0) ? $urandom :
				32'($urandom_range(0, 32'h8000_0000)) - COS_ONE;
			return pair(near_dist(), near_dist(), $urandom, $urandom, $urandom, $urandom, c);
		end
		if (pick < 98)
			return bin_read(pick < 88 ? FUNC_READ : FUNC_READ_CLR,
				$urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 255)));
		return bin_read(FUNC_UNUSED, 12'($urandom));
	endfunction

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		logic [6:0] np, nt;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero distances always land in bin 0; repeated full-scale products saturate it.
		repeat (3) send(pair(0, 0, '1, '1, 32'h8000_0000, 32'h8000_0000, COS_ONE));
		send(bin_read(FUNC_READ, 0));
		send(bin_read(FUNC_READ_CLR, 0));
		send(bin_read(FUNC_READ, 0));
		repeat (3) send(pair(32'h10000, 32'h10000, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF,
			COS_ONE));
		send(bin_read(FUNC_READ_CLR, 0));
		send(pair(0, 0, 5, 7, 32'hFFFF_FFFF, 3, 32'h7FFF_FFFF));
		send(pair(0, 0, 5, 7, 9, 32'h8000_0000, 32'h8000_0000));
		send(pair(32'h30000, 32'h10000, 32'h20000, 32'h30000, 1, 2, COS_MINUS_ONE));
		send(pair(32'h30000, 32'h10000, 32'h20000, 32'h30000, 1, 2, 32'h0));
		send(pair('1, 0, 1, 1, 1, 1, COS_ONE));
		send(pair('1, '1, 1, 1, 1, 1, COS_MINUS_ONE));
		send(pair(32'h31_0000, 0, 1, 1, 1, 1, COS_ONE));
		send(bin_read(FUNC_UNUSED, 12'd7));
		send(bin_read(FUNC_READ, 12'hFFF));
		send(bin_read(FUNC_READ, 12'd2));
		send(bin_read(FUNC_READ_CLR, 12'd0));
		settle();

		for (int phase = 0; phase < 16; phase++) begin
			quiet_mode = (phase % 4 == 3);
			case (phase)
				0: set_grid(7'd0, 7'd64, 32'h10000, 32'h10000);
				1: set_grid(7'd127, 7'd127, 32'h0, 32'h0);
				2: set_grid(7'd64, 7'd1, '1, '1);
				3: set_grid(7'd1, 7'd0, 32'h1, 32'h8000_0000);
				default: begin
					np = 7'($urandom_range(1, 64));
					nt = 7'($urandom_range(1, 64));
					max_dist = $urandom_range(4, 400);
					set_grid(np, nt, 32'(np) * 32'h10000 / max_dist,
						32'(nt) * 32'h10000 / (2 * max_dist));
				end
			endcase
			repeat (75) send(random_item());
			settle();
		end

		if (fail_count == 0)
			$display("weighted_pair_separation_histogram_core test passed");
		else
			$display("weighted_pair_separation_histogram_core test failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("weighted_pair_separation_histogram_core test failed");
		$finish;
	end
endmodule
